/* rtl/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 converter.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;
	localparam logic [1:0] KIND_FULL    = 2'd3;

	// surrogate ranges
	localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
	localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
	localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
	localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;

	// code point length thresholds
	localparam logic [20:0] CP_LIM_1B = 21'h00080;
	localparam logic [20:0] CP_LIM_2B = 21'h00800;
	localparam logic [20:0] CP_SUPP   = 21'h10000;

	localparam logic [31:0] CAP_RESET = 32'hFFFF_FFFF;

	// command queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// one command: the bytes of one code point and/or a terminating word
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nbytes;
		logic            term;
		logic [1:0]      term_kind;
		logic [31:0]     base;
	} u16u8_cmd_t;

endpackage

/* rtl/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, encodes code points and checks capacity.
// ----------------------------------------------------------------------------
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        accept,
	input  logic [15:0] code_unit,
	input  logic        end_of_input,
	output logic        cmd_push,
	output u16u8_cmd_t  cmd
);

	logic [31:0] cap_q;
	logic [9:0]  pend_high_q;
	logic        pend_valid_q;
	logic [31:0] bw_q;
	logic        halted_q;
	logic [1:0]  halt_kind_q;

	logic [9:0]  pend_high_d;
	logic        pend_valid_d;
	logic [31:0] bw_d;
	logic        halted_d;
	logic [1:0]  halt_kind_d;

	// classify, pair and encode one unit
	always_comb begin
		logic        is_high;
		logic        is_low;
		logic        have;
		logic [20:0] cp;
		logic [2:0]  n;
		logic [3:0][7:0] b;
		logic [32:0] sum;

		is_high = code_unit inside {[SURR_HI_FIRST:SURR_HI_LAST]};
		is_low  = code_unit inside {[SURR_LO_FIRST:SURR_LO_LAST]};
		have = 1'b0;
		cp = {5'd0, code_unit};
		pend_high_d  = pend_high_q;
		pend_valid_d = pend_valid_q;
		halted_d     = halted_q;
		halt_kind_d  = halt_kind_q;
		bw_d         = bw_q;
		cmd.nbytes   = 3'd0;

		if (!halted_q) begin
			if (pend_valid_q) begin
				if (is_low) begin
					cp = {1'b0, pend_high_q, code_unit[9:0]} + CP_SUPP;
					pend_valid_d = 1'b0;
					pend_high_d = 10'd0;
					have = 1'b1;
				end else begin
					halted_d = 1'b1;
					halt_kind_d = KIND_INVALID;
				end
			end else if (is_high) begin
				if (end_of_input) begin
					halted_d = 1'b1;
					halt_kind_d = KIND_INVALID;
				end else begin
					pend_high_d = code_unit[9:0];
					pend_valid_d = 1'b1;
				end
			end else if (is_low) begin
				halted_d = 1'b1;
				halt_kind_d = KIND_INVALID;
			end else begin
				have = 1'b1;
			end
		end

		// utf-8 byte layout
		b = '0;
		if (cp < CP_LIM_1B) begin
			n = 3'd1;
			b[0] = cp[7:0];
		end else if (cp < CP_LIM_2B) begin
			n = 3'd2;
			b[0] = {3'b110, cp[10:6]};
			b[1] = {2'b10, cp[5:0]};
		end else if (cp < CP_SUPP) begin
			n = 3'd3;
			b[0] = {4'b1110, cp[15:12]};
			b[1] = {2'b10, cp[11:6]};
			b[2] = {2'b10, cp[5:0]};
		end else begin
			n = 3'd4;
			b[0] = {5'b11110, cp[20:18]};
			b[1] = {2'b10, cp[17:12]};
			b[2] = {2'b10, cp[11:6]};
			b[3] = {2'b10, cp[5:0]};
		end

		// capacity check
		sum = {1'b0, bw_q} + {30'd0, n};
		if (have) begin
			if (sum > {1'b0, cap_q}) begin
				halted_d = 1'b1;
				halt_kind_d = KIND_FULL;
			end else begin
				cmd.nbytes = n;
				bw_d = sum[31:0];
			end
		end

		cmd.bytes     = b;
		cmd.term      = end_of_input;
		cmd.term_kind = halted_d ? halt_kind_d : KIND_DONE;
		cmd.base      = bw_q;
		cmd_push      = accept && (cmd.nbytes != 3'd0 || end_of_input);
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// per-string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_high_q  <= 10'd0;
			pend_valid_q <= 1'b0;
			bw_q         <= 32'd0;
			halted_q     <= 1'b0;
			halt_kind_q  <= KIND_DATA;
		end else if (accept) begin
			if (end_of_input) begin
				pend_high_q  <= 10'd0;
				pend_valid_q <= 1'b0;
				bw_q         <= 32'd0;
				halted_q     <= 1'b0;
				halt_kind_q  <= KIND_DATA;
			end else begin
				pend_high_q  <= pend_high_d;
				pend_valid_q <= pend_valid_d;
				bw_q         <= bw_d;
				halted_q     <= halted_d;
				halt_kind_q  <= halt_kind_d;
			end
		end
	end

endmodule

/* rtl/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue
// Small register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_queue
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  u16u8_cmd_t wr_cmd,
	output logic       q_full,
	input  logic       rd_en,
	output logic       rd_valid,
	output u16u8_cmd_t rd_cmd
);

	u16u8_cmd_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign q_full   = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// Turns commands into a result word per unstalled cycle in an output register.
// ----------------------------------------------------------------------------
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  u16u8_cmd_t  cmd,
	output logic        cmd_pop,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic [31:0] byte_count,
	output logic        last
);

	logic        busy_q;
	u16u8_cmd_t  cur_q;
	logic [2:0]  idx_q;
	logic [31:0] cnt_q;
	logic        ovalid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  kind_q;
	logic [31:0] byte_count_q;
	logic        last_q;

	logic        adv;
	logic        is_data;
	logic        res_last;
	logic        fin;
	logic        load;
	logic [31:0] cnt_inc;

	assign empty      = !ovalid_q;
	assign out_byte   = out_byte_q;
	assign kind       = kind_q;
	assign byte_count = byte_count_q;
	assign last       = last_q;

	// step control
	always_comb begin
		adv      = !ovalid_q || pop;
		is_data  = idx_q < cur_q.nbytes;
		cnt_inc  = cnt_q + 32'd1;
		res_last = is_data ? ((idx_q + 3'd1 == cur_q.nbytes) && !cur_q.term) : 1'b1;
		fin      = busy_q && adv && res_last;
		load     = cmd_valid && (!busy_q || fin);
		cmd_pop  = load;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			out_byte_q   <= is_data ? cur_q.bytes[idx_q[1:0]] : 8'd0;
			kind_q       <= is_data ? KIND_DATA : cur_q.term_kind;
			byte_count_q <= is_data ? cnt_inc : cnt_q;
			last_q       <= res_last;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && adv && is_data) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd;
			cnt_q <= cmd.base;
		end else if (busy_q && adv && is_data) begin
			cnt_q <= cnt_inc;
		end
	end

endmodule

/* rtl/utf16_to_utf8_converter_core.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter_core
// UTF-16 code units in, UTF-8 byte words and terminating status words out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  input    | in        | push / full        | code_unit, end_of_input
//  result   | out       | empty / pop        | out_byte, kind, byte_count, last
//  config   | in        | cfg_wr_en          | cfg_wr_data (out_capacity)
//
//  the front takes one code unit per cycle while the command queue has room
//  the back sends one result word per cycle while pop is not stalled: a unit
//  yields 0 to 5 words there (its utf-8 bytes plus one for the end of the
//  string; none for a held high surrogate or a unit after a halt)
//  a stalled pop holds the output register; the four-entry queue lets the
//  front keep accepting until it fills
//  reset clears all control state; out_capacity resets to all ones
// ----------------------------------------------------------------------------
module utf16_to_utf8_converter_core
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        end_of_input,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic [31:0] byte_count,
	output logic        last
);

	logic       accept;
	logic       cmd_push;
	u16u8_cmd_t fe_cmd;
	logic       q_valid;
	logic       q_pop;
	u16u8_cmd_t q_cmd;

	assign accept = push && !full;

	// classify and encode
	u16u8_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.accept       (accept),
		.code_unit    (code_unit),
		.end_of_input (end_of_input),
		.cmd_push     (cmd_push),
		.cmd          (fe_cmd)
	);

	// command queue
	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (fe_cmd),
		.q_full   (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	// byte serializer
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (q_cmd),
		.cmd_pop    (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.kind       (kind),
		.byte_count (byte_count),
		.last       (last)
	);

	// a status word always closes the unit that caused it
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_DATA) |-> last)
		else $error("status word without last");

	// status words carry no byte
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_DATA) |-> (out_byte == 8'd0))
		else $error("status word with nonzero byte");

	// a data word counts itself
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DATA) |-> (byte_count != 32'd0))
		else $error("data word with zero count");

	// the back never pops an empty queue
	a_queue_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue read while empty");

endmodule
